// ===== rtl/skt_pkg.sv =====
// Package for the sorted key table: widths, depth, operation and status codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package skt_pkg;

    localparam int DEPTH       = 64;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int OPC_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_FW    = 7;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 16;
    localparam int M_PAYLOAD_W = STATUS_W + 2 + COUNT_FW;

    typedef logic [CNT_W-1:0] count_t;
    typedef logic [KEY_W-1:0] key_t;
    typedef logic [TAG_W-1:0] tag_t;
    typedef logic [DEPTH-1:0] cell_vec_t;

    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic apply;
    } skt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } skt_stat_t;

endpackage

// ===== rtl/skt_datapath.sv =====
// Datapath of the sorted key table: a row of key/tag cells with per-cell
// comparators, the occupancy count and the result register.
// Depends on skt_pkg.
module skt_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  skt_pkg::skt_cmd_t             cmd,
    output skt_pkg::skt_stat_t            stat,
    input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,   // key [31:0], record_tag [47:32]
    input  logic [skt_pkg::OPC_W-1:0]     s_tuser,   // opcode [1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [skt_pkg::M_TDATA_W-1:0] m_tdata    // status [1:0], found [2],
                                                     // is_empty [3], entry_count [10:4]
);

    skt_pkg::key_t      key_reg [skt_pkg::DEPTH];
    skt_pkg::tag_t      tag_reg [skt_pkg::DEPTH];
    skt_pkg::key_t      key_next [skt_pkg::DEPTH];
    skt_pkg::tag_t      tag_next [skt_pkg::DEPTH];
    skt_pkg::count_t    occ_reg, occ_next;
    skt_pkg::opcode_t   op_reg;
    skt_pkg::key_t      in_key_reg;
    skt_pkg::tag_t      in_tag_reg;
    skt_pkg::cell_vec_t lt_reg, eq_reg, ge_reg;
    skt_pkg::cell_vec_t lt_now, eq_now, ge_now;
    logic               m_tvalid_reg;
    logic [skt_pkg::M_PAYLOAD_W-1:0] m_payload_reg, m_payload_next;

    skt_pkg::key_t      s_key;
    logic               hit, full, do_insert, do_remove, found;
    skt_pkg::status_t   status;

    assign s_key = s_tdata[skt_pkg::KEY_W-1:0];

    // Per-cell compare against the incoming key; cells past the count never match.
    genvar i;
    generate
        for (i = 0; i < skt_pkg::DEPTH; i++) begin : g_cmp
            logic valid;
            assign valid     = skt_pkg::count_t'(i) < occ_reg;
            assign lt_now[i] = valid && (key_reg[i] < s_key);
            assign eq_now[i] = valid && (key_reg[i] == s_key);
            assign ge_now[i] = valid && !(key_reg[i] < s_key);
        end
    endgenerate

    assign hit       = |eq_reg;
    assign full      = occ_reg == skt_pkg::count_t'(skt_pkg::DEPTH);
    assign do_insert = (op_reg == skt_pkg::OP_INSERT) && !full;
    assign do_remove = (op_reg == skt_pkg::OP_REMOVE) && hit;

    // Cell update: insert opens a gap at the first cell not below the key,
    // remove closes the gap from the first matching cell onward.
    generate
        for (i = 0; i < skt_pkg::DEPTH; i++) begin : g_cell
            skt_pkg::key_t prev_key, succ_key;
            skt_pkg::tag_t prev_tag, succ_tag;
            logic          prev_lt;
            if (i == 0) begin : g_first
                assign prev_key = in_key_reg;
                assign prev_tag = in_tag_reg;
                assign prev_lt  = 1'b1;
            end else begin : g_mid
                assign prev_key = key_reg[i-1];
                assign prev_tag = tag_reg[i-1];
                assign prev_lt  = lt_reg[i-1];
            end
            if (i == skt_pkg::DEPTH - 1) begin : g_last
                assign succ_key = key_reg[i];
                assign succ_tag = tag_reg[i];
            end else begin : g_inner
                assign succ_key = key_reg[i+1];
                assign succ_tag = tag_reg[i+1];
            end

            always_comb begin
                key_next[i] = key_reg[i];
                tag_next[i] = tag_reg[i];
                if (do_insert && !lt_reg[i]) begin
                    if (prev_lt) begin
                        key_next[i] = in_key_reg;
                        tag_next[i] = in_tag_reg;
                    end else begin
                        key_next[i] = prev_key;
                        tag_next[i] = prev_tag;
                    end
                end else if (do_remove && ge_reg[i]) begin
                    key_next[i] = succ_key;
                    tag_next[i] = succ_tag;
                end
            end

            always_ff @(posedge aclk) begin
                if (cmd.apply) begin
                    key_reg[i] <= key_next[i];
                    tag_reg[i] <= tag_next[i];
                end
            end
        end
    endgenerate

    always_comb begin
        occ_next = occ_reg;
        status   = skt_pkg::ST_DONE;
        found    = 1'b0;
        unique case (op_reg)
            skt_pkg::OP_INSERT: begin
                if (full) begin
                    status = skt_pkg::ST_FULL;
                end else begin
                    occ_next = occ_reg + skt_pkg::count_t'(1);
                end
            end
            skt_pkg::OP_REMOVE: begin
                if (hit) begin
                    occ_next = occ_reg - skt_pkg::count_t'(1);
                    found    = 1'b1;
                end else begin
                    status = skt_pkg::ST_NOT_FOUND;
                end
            end
            skt_pkg::OP_QUERY: begin
                found = hit;
            end
            default: begin
                status = skt_pkg::ST_DONE;
            end
        endcase
        m_payload_next = {skt_pkg::COUNT_FW'(occ_next),
                          occ_next == '0,
                          found,
                          status};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            lt_reg       <= '0;
            eq_reg       <= '0;
            ge_reg       <= '0;
            op_reg       <= skt_pkg::OP_QUERY;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                lt_reg <= lt_now;
                eq_reg <= eq_now;
                ge_reg <= ge_now;
                op_reg <= skt_pkg::opcode_t'(s_tuser);
            end
            if (cmd.apply) begin
                occ_reg      <= occ_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_key_reg <= s_key;
            in_tag_reg <= s_tdata[skt_pkg::KEY_W +: skt_pkg::TAG_W];
        end
        if (cmd.apply) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = skt_pkg::M_TDATA_W'(m_payload_reg);

    // Cells below the key always form a prefix of a sorted row.
    a_lt_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        (lt_reg & (lt_reg + skt_pkg::cell_vec_t'(1))) == '0)
        else $error("cells below key are not a prefix");

    // Matching cells lie within the not-below region.
    a_eq_in_ge: assert property (@(posedge aclk) disable iff (!aresetn)
        (eq_reg & ~ge_reg) == '0)
        else $error("match outside not-below region");

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= skt_pkg::count_t'(skt_pkg::DEPTH))
        else $error("occupancy beyond depth");

    // Never overwrite a result that is still waiting.
    a_apply_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && do_insert) |=> occ_reg == $past(occ_reg) + skt_pkg::count_t'(1))
        else $error("insert did not advance count");

endmodule

// ===== rtl/skt_ctrl.sv =====
// Controller of the sorted key table: two-state sequencer that accepts a
// transaction, then applies it once the result register is free.
// Depends on skt_pkg.
module skt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  skt_pkg::skt_stat_t stat,
    output skt_pkg::skt_cmd_t  cmd
);

    skt_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            skt_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = skt_pkg::S_EXEC;
                end
            end
            skt_pkg::S_EXEC: begin
                if (stat.out_free) begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.apply   = 1'b0;
        unique case (state_reg)
            skt_pkg::S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            skt_pkg::S_EXEC: begin
                cmd.apply = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= skt_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A capture is always followed by an apply attempt.
    a_capture_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> state_reg == skt_pkg::S_EXEC)
        else $error("capture not followed by execute");

    // Hold in execute while the result register is busy.
    a_hold_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == skt_pkg::S_EXEC && !stat.out_free) |=> state_reg == skt_pkg::S_EXEC)
        else $error("left execute with result register busy");

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.capture && cmd.apply))
        else $error("capture and apply together");

endmodule

// ===== rtl/sorted_key_table_top.sv =====
// Top level of the sorted key table: ties the controller and the cell datapath
// to the input and result stream ports.
// Depends on skt_pkg, skt_ctrl, skt_datapath.
//
//  channel  dir  handshake           payload
//  s_       in   s_tvalid/s_tready   s_tdata: key, record_tag; s_tuser: opcode
//  m_       out  m_tvalid/m_tready   m_tdata: status, found, is_empty, entry_count
//
// Each transaction is accepted in the idle state, where its key is compared against
// every cell in parallel; the execute state then shifts the cells and loads the result register.
// The result register lets the next transaction be accepted while a result waits;
// a busy result register holds the block in its execute cycle.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass.
module sorted_key_table_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [skt_pkg::S_TDATA_W-1:0] s_tdata,   // key [31:0], record_tag [47:32]
    input  logic [skt_pkg::OPC_W-1:0]     s_tuser,   // opcode [1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [skt_pkg::M_TDATA_W-1:0] m_tdata    // status [1:0], found [2],
                                                     // is_empty [3], entry_count [10:4]
);

    skt_pkg::skt_cmd_t  cmd;
    skt_pkg::skt_stat_t stat;

    skt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skt_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== verif/sorted_key_table_top_tb.sv =====
// Self-checking testbench for sorted_key_table_top: directed table operations, then
// phased random insert/remove/query traffic with bursty input and a stalling receiver.
// Depends on skt_pkg and the sorted_key_table_top RTL.
module sorted_key_table_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [skt_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int PHASE_ITEMS   = 83;
    localparam int NUM_PHASES    = 10;
    localparam int PAUSE_PHASE   = 5;
    localparam int HOLD_AFTER    = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS = 3_000_000;

    typedef struct packed {
        skt_pkg::status_t               status;
        logic                           found;
        logic                           is_empty;
        logic [skt_pkg::COUNT_FW-1:0]   entry_count;
    } table_result_t;

    typedef struct {
        logic [skt_pkg::OPC_W-1:0] op;
        skt_pkg::key_t             key;
        skt_pkg::tag_t             tag;
        bit                        fixed;    // expectation typed in rather than predicted
        table_result_t             want;
    } table_row_t;

    typedef enum { PH_FILL, PH_DRAIN, PH_MIXED } phase_t;
    typedef enum { RX_OPEN, RX_COIN, RX_SLOW, RX_PATTERN } rx_mode_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [skt_pkg::S_TDATA_W-1:0]   s_tdata  = '0;
    logic [skt_pkg::OPC_W-1:0]       s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [skt_pkg::M_TDATA_W-1:0]   m_tdata;

    // shadow copy of the table, kept in ascending key order
    skt_pkg::key_t  shadow_keys[$];
    skt_pkg::tag_t  shadow_tags[$];
    table_result_t  pending_results[$];
    table_row_t     directed_rows[$];

    int  fail_count  = 0;
    int  items_sent  = 0;
    int  burst_left  = 0;

    sorted_key_table_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic table_result_t apply_table_op(logic [skt_pkg::OPC_W-1:0] op,
                                                     skt_pkg::key_t key, skt_pkg::tag_t tag);
        table_result_t res;
        int pos;
        res = '{skt_pkg::ST_DONE, 1'b0, 1'b0, '0};
        case (op)
            skt_pkg::OP_INSERT: begin
                if (shadow_keys.size() >= skt_pkg::DEPTH) begin
                    res.status = skt_pkg::ST_FULL;
                end else begin
                    // new key goes in front of any equal keys
                    pos = 0;
                    while (pos < shadow_keys.size() && shadow_keys[pos] < key) pos++;
                    shadow_keys.insert(pos, key);
                    shadow_tags.insert(pos, tag);
                end
            end
            skt_pkg::OP_REMOVE, skt_pkg::OP_QUERY: begin
                pos = -1;
                foreach (shadow_keys[i]) begin
                    if (pos < 0 && shadow_keys[i] == key) pos = i;
                end
                if (pos < 0) begin
                    if (op == skt_pkg::OP_REMOVE) res.status = skt_pkg::ST_NOT_FOUND;
                end else begin
                    res.found = 1'b1;
                    if (op == skt_pkg::OP_REMOVE) begin
                        shadow_keys.delete(pos);
                        shadow_tags.delete(pos);
                    end
                end
            end
            default: ;
        endcase
        res.is_empty    = (shadow_keys.size() == 0);
        res.entry_count = skt_pkg::COUNT_FW'(shadow_keys.size());
        return res;
    endfunction

    function automatic table_row_t make_row(logic [skt_pkg::OPC_W-1:0] op,
                                            skt_pkg::key_t key, skt_pkg::tag_t tag,
                                            bit fixed, table_result_t want);
        table_row_t row;
        row.op    = op;
        row.key   = key;
        row.tag   = tag;
        row.fixed = fixed;
        row.want  = want;
        return row;
    endfunction

    function automatic void pick_random_item(phase_t ph,
                                             output logic [skt_pkg::OPC_W-1:0] op,
                                             output skt_pkg::key_t key,
                                             output skt_pkg::tag_t tag);
        int roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  op = (roll < 90) ? skt_pkg::OP_INSERT :
                           (roll < 95) ? skt_pkg::OP_QUERY :
                           (roll < 98) ? skt_pkg::OP_REMOVE : OP_UNUSED;
            PH_DRAIN: op = (roll < 75) ? skt_pkg::OP_REMOVE :
                           (roll < 87) ? skt_pkg::OP_QUERY :
                           (roll < 95) ? skt_pkg::OP_INSERT : OP_UNUSED;
            default:  op = (roll < 40) ? skt_pkg::OP_INSERT :
                           (roll < 70) ? skt_pkg::OP_REMOVE :
                           (roll < 92) ? skt_pkg::OP_QUERY : OP_UNUSED;
        endcase
        // aim most removes and queries at held keys so they hit
        if ((op == skt_pkg::OP_REMOVE || op == skt_pkg::OP_QUERY) && shadow_keys.size() > 0 &&
            $urandom_range(0, 3) != 0) begin
            key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
        end else begin
            case ($urandom_range(0, 9))
                0: case ($urandom_range(0, 3))
                       0: key = 32'h0000_0000;
                       1: key = 32'hFFFF_FFFF;
                       2: key = 32'h7FFF_FFFF;
                       default: key = 32'h8000_0000;
                   endcase
                1, 2, 3, 4: key = $urandom_range(0, 15);
                default: key = $urandom;
            endcase
        end
        tag = 16'($urandom_range(0, 65535));
    endfunction

    // offer one transaction; returns at the falling edge after it is accepted
    task automatic offer_item(logic [skt_pkg::OPC_W-1:0] op, skt_pkg::key_t key,
                              skt_pkg::tag_t tag, bit fixed, table_result_t want);
        table_result_t predicted;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {tag, key};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_table_op(op, key, tag);
        pending_results.push_back(fixed ? want : predicted);
        burst_left--;
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // stimulus
    initial begin
        table_result_t empty_done;
        table_result_t none;
        logic [skt_pkg::OPC_W-1:0] op;
        skt_pkg::key_t key;
        skt_pkg::tag_t tag;
        phase_t ph;

        empty_done = '{skt_pkg::ST_DONE, 1'b0, 1'b1, 7'd0};
        none       = '0;

        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'h0000_0000, 16'h0000, 1,
                                         empty_done));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000, 1,
                                         '{skt_pkg::ST_NOT_FOUND, 1'b0, 1'b1, 7'd0}));
        directed_rows.push_back(make_row(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1, empty_done));
        directed_rows.push_back(make_row(skt_pkg::OP_INSERT, 32'h0000_0000, 16'h0000, 1,
                                         '{skt_pkg::ST_DONE, 1'b0, 1'b0, 7'd1}));
        directed_rows.push_back(make_row(skt_pkg::OP_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1,
                                         '{skt_pkg::ST_DONE, 1'b0, 1'b0, 7'd2}));
        directed_rows.push_back(make_row(skt_pkg::OP_INSERT, 32'h8000_0000, 16'hAAAA, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_INSERT, 32'h8000_0000, 16'h5555, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'h8000_0000, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'h7FFF_FFFF, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h8000_0000, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'h8000_0000, 16'hFFFF, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h1234_5678, 16'hFFFF, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'hFFFF_FFFF, 16'hFFFF, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_INSERT, 32'h0000_0001, 16'h0001, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'hFFFF_FFFF, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h0000_0000, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(OP_UNUSED, 32'h0000_0001, 16'h0000, 0, none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h8000_0000, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_REMOVE, 32'h0000_0001, 16'h0000, 0,
                                         none));
        directed_rows.push_back(make_row(skt_pkg::OP_QUERY, 32'h0000_0000, 16'h0000, 1,
                                         empty_done));

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].tag,
                       directed_rows[i].fixed, directed_rows[i].want);
        end

        // fill to full first, then drain past empty, then mix at random
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: ph = PH_FILL;
                1: ph = PH_DRAIN;
                default: ph = phase_t'($urandom_range(0, 2));
            endcase
            if (p == PAUSE_PHASE) begin
                s_tvalid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge aclk);
                burst_left = 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick_random_item(ph, op, key, tag);
                offer_item(op, key, tag, 1'b0, none);
            end
        end

        s_tvalid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // receiver: stall pattern of its own, plus one long hold to back the block up
    initial begin
        rx_mode_t rx_mode;
        int  mode_left;
        int  hold_left;
        bit  hold_done;
        logic [7:0] pattern;
        rx_mode   = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        pattern   = 8'b1011_0010;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!hold_done && items_sent >= HOLD_AFTER) begin
                hold_done = 1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 80);
                    pattern   = 8'($urandom_range(1, 255));
                end
                mode_left--;
                case (rx_mode)
                    RX_OPEN:  m_tready <= 1'b1;
                    RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                    RX_SLOW:  m_tready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        m_tready <= pattern[0];
                        pattern = {pattern[0], pattern[7:1]};
                    end
                endcase
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        table_result_t got;
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = skt_pkg::status_t'(m_tdata[1:0]);
            got.found       = m_tdata[2];
            got.is_empty    = m_tdata[3];
            got.entry_count = m_tdata[10:4];
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result with nothing outstanding, tdata %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.found !== want.found ||
                    got.is_empty !== want.is_empty || got.entry_count !== want.entry_count)
                begin
                    note_failure($sformatf(
                        "expected status %0d found %0b empty %0b count %0d, got %0d %0b %0b %0d",
                        want.status, want.found, want.is_empty, want.entry_count,
                        got.status, got.found, got.is_empty, got.entry_count));
                end
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/skt_pkg.sv
rtl/skt_datapath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table_top.sv
verif/sorted_key_table_top_tb.sv
